// ===== src/att_pkg.sv =====
// att_pkg: shared constants for the assembly token coder
// character codes, error codes and the mnemonic table; no dependencies
package att_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;

  localparam int OP_COUNT = 18;
  localparam int CODE_W   = 5;

  // names right aligned: last character in the low byte, zero above the first
  localparam logic [63:0] OP_NAMES [OP_COUNT] = '{
    64'("PUSH"), 64'("POP"),  64'("ADD"),   64'("SUB"),  64'("MUL"),
    64'("AND"),  64'("OR"),   64'("NOT"),   64'("LT"),   64'("EQ"),
    64'("JMP"),  64'("JZ"),   64'("LOAD"),  64'("STORE"), 64'("CALL"),
    64'("RET"),  64'("PRINT"), 64'("HALT")
  };

  localparam logic [3:0] OP_LENS [OP_COUNT] = '{
    4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2,
    4'd2, 4'd3, 4'd2, 4'd4, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4
  };

endpackage

// ===== src/att_in_if.sv =====
// att_in_if: character channel into the assembly token coder
// valid/ready handshake with one text byte and an end-of-text mark
interface att_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

// ===== src/att_out_if.sv =====
// att_out_if: result channel out of the assembly token coder
// valid/ready handshake with value, literal flag and error code
interface att_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] token_value;
  logic               is_literal;
  logic [1:0]         error_code;

  modport source (output valid, output token_value, output is_literal, output error_code,
                  input ready);
  modport sink   (input valid, input token_value, input is_literal, input error_code,
                  output ready);
endinterface

// ===== src/assembly_token_to_code_core.sv =====
// Assembly token coder: takes one text byte per cycle and gives one result per finished
// token (a separator after a token, or the byte marked end of text). The transfer that
// finishes a token loads it into the snapshot, whose decode is registered into the output
// register when free, and input is held off only while a finished token waits in the
// snapshot behind a stalled result. The character accumulator feeds a one-entry token
// snapshot, which is decoded (range check, negate, parallel compare against the 18
// mnemonics) into the output register. Tokens longer than MNEMONIC_CHARS bytes that are
// not literals come out as unknown. Depends on att_pkg, att_in_if and att_out_if.
module assembly_token_to_code_core #(
  parameter int MNEMONIC_CHARS = 5
) (
  input  logic      clk,
  input  logic      rst,
  att_in_if.sink    text_in,
  att_out_if.source code_out
);

  localparam int LenW  = $clog2(MNEMONIC_CHARS + 1);
  localparam int CharW = 8 * MNEMONIC_CHARS;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CharW-1:0] chars;
    logic             too_long;
    logic [31:0]      mag;
    logic             mag_ovf;
    logic             neg;
    logic             sign_first;
    logic             digits_only;
  } tok_t;

  tok_t tok, tok_next, tok_upd, tok_clear, snap_data;
  tok_t snap;
  logic snap_valid;

  logic               out_valid;
  logic signed [31:0] token_value;
  logic               is_literal;
  logic [1:0]         error_code;

  logic [7:0]  c;
  logic        is_sep, is_digit, is_sign, first, pending;
  logic        accept, finish, out_free, snap_free;
  logic [35:0] mag_x10;

  // decode of the snapshot
  logic                    lit, over, hit;
  logic [att_pkg::CODE_W-1:0] code;
  logic [31:0]             lit_value;
  logic signed [31:0]      dec_value;
  logic [1:0]              dec_err;

  assign c        = text_in.text_char;
  assign is_sep   = (c == att_pkg::CHAR_SPACE) || (c == att_pkg::CHAR_LF) ||
                    (c == att_pkg::CHAR_TAB) || (c == att_pkg::CHAR_CR);
  assign is_digit = (c >= att_pkg::CHAR_ZERO) && (c <= att_pkg::CHAR_NINE);
  assign is_sign  = (c == att_pkg::CHAR_PLUS) || (c == att_pkg::CHAR_MINUS);
  assign first    = (tok.len == '0) && !tok.too_long;
  assign pending  = (tok.len != '0) || tok.too_long;

  assign out_free      = !out_valid || code_out.ready;
  assign snap_free     = !snap_valid || out_free;
  assign text_in.ready = snap_free;
  assign accept        = text_in.valid && snap_free;
  assign finish        = accept && (is_sep ? pending : text_in.end_of_text);

  // magnitude * 10 + digit as two shifts and two adds
  assign mag_x10 = ({4'b0, tok.mag} << 3) + ({4'b0, tok.mag} << 1) + {32'b0, c[3:0]};

  always_comb begin
    tok_clear             = '0;
    tok_clear.digits_only = 1'b1;

    tok_upd = tok;
    if (first && is_sign) begin
      tok_upd.sign_first = 1'b1;
      tok_upd.neg        = (c == att_pkg::CHAR_MINUS);
    end else if (is_digit) begin
      if (mag_x10[35:32] != 4'b0) begin
        tok_upd.mag_ovf = 1'b1;
        tok_upd.mag     = '1;
      end else begin
        tok_upd.mag = mag_x10[31:0];
      end
    end else begin
      tok_upd.digits_only = 1'b0;
    end

    // characters shift in at the low end so names compare right aligned
    if (tok.len < LenW'(MNEMONIC_CHARS)) begin
      tok_upd.chars = {tok.chars[CharW-9:0], c};
      tok_upd.len   = tok.len + LenW'(1);
    end else begin
      tok_upd.too_long = 1'b1;
    end

    snap_data = is_sep ? tok : tok_upd;

    tok_next = tok;
    if (finish) begin
      tok_next = tok_clear;
    end else if (accept && !is_sep) begin
      tok_next = tok_upd;
    end
  end

  always_comb begin
    lit  = snap.digits_only && (!snap.sign_first || (snap.len >= LenW'(2)) || snap.too_long);
    over = snap.mag_ovf || (snap.neg ? (snap.mag > 32'h8000_0000) : (snap.mag > 32'h7FFF_FFFF));
    lit_value = snap.neg ? (32'd0 - snap.mag) : snap.mag;

    hit  = 1'b0;
    code = '0;
    for (int k = 0; k < att_pkg::OP_COUNT; k++) begin
      if (!hit && (4'(snap.len) == att_pkg::OP_LENS[k]) &&
          (snap.chars == att_pkg::OP_NAMES[k][CharW-1:0])) begin
        hit  = 1'b1;
        code = att_pkg::CODE_W'(k);
      end
    end

    if (lit) begin
      dec_err   = over ? att_pkg::ERR_RANGE : att_pkg::ERR_OK;
      dec_value = over ? 32'sd0 : $signed(lit_value);
    end else if (hit && !snap.too_long) begin
      dec_err   = att_pkg::ERR_OK;
      dec_value = $signed({{(32 - att_pkg::CODE_W){1'b0}}, code});
    end else begin
      dec_err   = att_pkg::ERR_UNKNOWN;
      dec_value = 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok        <= tok_clear;
      snap_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      tok <= tok_next;
      if (finish) begin
        snap_valid <= 1'b1;
      end else if (out_free) begin
        snap_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= snap_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      snap <= snap_data;
    end
    if (out_free && snap_valid) begin
      token_value <= dec_value;
      is_literal  <= lit;
      error_code  <= dec_err;
    end
  end

  assign code_out.valid       = out_valid;
  assign code_out.token_value = token_value;
  assign code_out.is_literal  = is_literal;
  assign code_out.error_code  = error_code;

endmodule

// ===== src/att_checker.sv =====
// att_checker: port-level checks on the assembly token coder
// bound to assembly_token_to_code_core; depends on att_pkg
module att_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] token_value,
  input logic               is_literal,
  input logic [1:0]         error_code
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_value) &&
      $stable(is_literal) && $stable(error_code))
    else $error("result changed while stalled");

  // errors always carry a zero value and a legal code
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code == att_pkg::ERR_OK) ||
      ((error_code == att_pkg::ERR_UNKNOWN || error_code == att_pkg::ERR_RANGE) &&
       token_value == 32'sd0))
    else $error("bad error code or nonzero value on error");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code != att_pkg::ERR_RANGE || is_literal) &&
      (error_code != att_pkg::ERR_UNKNOWN || !is_literal))
    else $error("error code does not match token kind");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_literal && error_code == att_pkg::ERR_OK |->
      token_value >= 32'sd0 && token_value < 32'(att_pkg::OP_COUNT))
    else $error("mnemonic code out of range");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind assembly_token_to_code_core att_checker u_att_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (code_out.valid),
  .out_ready   (code_out.ready),
  .token_value (code_out.token_value),
  .is_literal  (code_out.is_literal),
  .error_code  (code_out.error_code)
);
